>>> hdl/dlcs_pkg.sv
`default_nettype none
package dlcs_pkg;

   localparam int IDX_W     = 16;
   localparam int FRAC_W    = 8;
   localparam int DLY_W     = IDX_W + FRAC_W;
   localparam int SF_W      = 32;
   localparam int HCR_W     = 48;
   localparam int AMP_W     = 15;
   localparam int OUT_W     = 16;
   localparam int PH_W      = 24;
   localparam int ACC_W     = 40;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;
   localparam int CORD_W    = 32;
   localparam int ITERS     = 28;
   localparam int CORD_FRAC = 14;
   localparam int LATENCY   = 36;

   localparam logic [CSR_IDX_W-1:0] REG_START_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE  = 2'd2;

   localparam logic [31:0]      CORDIC_GAIN = 32'h9B74_EDA8;
   localparam logic [AMP_W-1:0] AMP_RESET   = 15'h7FFF;

   typedef logic signed [CORD_W-1:0] cord_type;

   function automatic logic [31:0] atan_turn(input int k);
      logic [31:0] r;
      begin
         case (k)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
           12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
           15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
           18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
           21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
           24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
           27: r = 32'h00000005;
           default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/delayed_lfm_chirp_sample.sv
`default_nettype none
// The 28-stage CORDIC pipeline follows the phase-accumulation stages and ends in a rounding stage.
// Throughput: one sample per clock; busy stays low, so start may be high every cycle.
// Synchronous active-high reset clears all valid bits and loads register defaults
// (start_freq 0, half_chirp_rate 0, amplitude 32767).
module delayed_lfm_chirp_sample (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [dlcs_pkg::IDX_W-1:0]          req_sample_index,
   input  wire  [dlcs_pkg::DLY_W-1:0]          req_delay_samples,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [dlcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [dlcs_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   output logic signed [dlcs_pkg::OUT_W-1:0]   rsp_i_out,
   output logic signed [dlcs_pkg::OUT_W-1:0]   rsp_q_out,
   output logic                                rsp_before_delay
);
   import dlcs_pkg::*;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration
   logic [SF_W-1:0]  sf_ff;
   logic [HCR_W-1:0] hcr_ff;
   logic [AMP_W-1:0] amp_ff;
   logic [29:0]      x0_ff;
   logic [46:0]      x0_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff  <= '0;
         hcr_ff <= '0;
         amp_ff <= AMP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_START_FREQ: sf_ff  <= csr_wdata[SF_W-1:0];
            REG_HALF_RATE:  hcr_ff <= csr_wdata[HCR_W-1:0];
            REG_AMPLITUDE:  amp_ff <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // scaled CORDIC start magnitude, round(amp * K * 2^14)
   assign x0_in = 47'(amp_ff) * 47'(CORDIC_GAIN) + 47'(1 << (31 - CORD_FRAC));
   always_ff @(posedge clock) x0_ff <= {1'b0, x0_in[46:18]};

   // stage 1: delay compare and subtract
   logic [DLY_W-1:0] idx_fx;
   logic [DLY_W:0]   diff_in;
   logic [DLY_W-1:0] tl_ff;
   logic             v1_ff, b1_ff;

   assign idx_fx  = {req_sample_index, {FRAC_W{1'b0}}};
   assign diff_in = {1'b0, idx_fx} - {1'b0, req_delay_samples};

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      tl_ff <= diff_in[DLY_W-1:0];
      b1_ff <= diff_in[DLY_W];
   end

   // stage 2: tl^2 and linear term
   logic signed [56:0] lin_in;
   logic [47:0]        tl2_in, tl2_ff;
   logic [ACC_W-1:0]   lin2_ff;
   logic               v2_ff, b2_ff;

   assign lin_in = $signed(sf_ff) * $signed({1'b0, tl_ff});
   assign tl2_in = 48'(tl_ff) * 48'(tl_ff);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      b2_ff   <= b1_ff;
      lin2_ff <= lin_in[ACC_W-1:0];
      tl2_ff  <= tl2_in;
   end

   // stage 3: partial products of half_chirp_rate * tl^2
   logic [47:0]        pp00_in, pp01_in, pp00_ff, pp01_ff;
   logic signed [48:0] pp10_in, pp11_in, pp10_ff, pp11_ff;
   logic [ACC_W-1:0]   lin3_ff;
   logic               v3_ff, b3_ff;

   assign pp00_in = 48'(hcr_ff[23:0]) * 48'(tl2_ff[23:0]);
   assign pp01_in = 48'(hcr_ff[23:0]) * 48'(tl2_ff[47:24]);
   assign pp10_in = $signed(hcr_ff[47:24]) * $signed({1'b0, tl2_ff[23:0]});
   assign pp11_in = $signed(hcr_ff[47:24]) * $signed({1'b0, tl2_ff[47:24]});

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      b3_ff   <= b2_ff;
      lin3_ff <= lin2_ff;
      pp00_ff <= pp00_in;
      pp01_ff <= pp01_in;
      pp10_ff <= pp10_in;
      pp11_ff <= pp11_in;
   end

   // stage 4: middle cross terms
   logic signed [49:0] mid_in, mid_ff;
   logic [47:0]        pp00_4_ff;
   logic signed [48:0] pp11_4_ff;
   logic [ACC_W-1:0]   lin4_ff;
   logic               v4_ff, b4_ff;

   assign mid_in = $signed({2'b00, pp01_ff}) + 50'(pp10_ff);

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      b4_ff     <= b3_ff;
      lin4_ff   <= lin3_ff;
      mid_ff    <= mid_in;
      pp00_4_ff <= pp00_ff;
      pp11_4_ff <= pp11_ff;
   end

   // stage 5: quadratic term modulo 2^72, keep bits [71:32]
   logic [71:0]      quad_in;
   logic [ACC_W-1:0] quad5_ff, lin5_ff;
   logic             v5_ff, b5_ff;

   assign quad_in = 72'(pp00_4_ff)
                  + ({72'(mid_ff)} << 24)
                  + ({72'(pp11_4_ff)} << 48);

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      b5_ff    <= b4_ff;
      lin5_ff  <= lin4_ff;
      quad5_ff <= quad_in[71:32];
   end

   // stage 6: phase sum, upper 40 bits of the 64-bit cycle fraction
   logic [ACC_W-1:0] ph_ff;
   logic             v6_ff, b6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      b6_ff <= b5_ff;
      ph_ff <= lin5_ff + quad5_ff;
   end

   // stage 7: round phase, fold into +-quarter turn
   logic [ACC_W-1:0] ph_rnd;
   cord_type         z_in, z_fold, x_init, x0_s;
   logic             far;

   assign ph_rnd = ph_ff + ACC_W'(1 << 15);
   assign z_in   = {ph_rnd[ACC_W-1:ACC_W-PH_W], {(CORD_W-PH_W){1'b0}}};
   assign far    = (z_in > 32'sh4000_0000) || (z_in < -32'sh4000_0000);
   assign z_fold = far ? {~z_in[CORD_W-1], z_in[CORD_W-2:0]} : z_in;
   assign x0_s   = $signed({2'b00, x0_ff});
   assign x_init = far ? -x0_s : x0_s;

   cord_type cx_ff [0:ITERS];
   cord_type cy_ff [0:ITERS];
   cord_type cz_ff [0:ITERS];
   logic     cv_ff [0:ITERS];
   logic     cb_ff [0:ITERS];

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else       cv_ff[0] <= v6_ff;
      cb_ff[0] <= b6_ff;
      cx_ff[0] <= x_init;
      cy_ff[0] <= '0;
      cz_ff[0] <= z_fold;
   end

   // CORDIC rotation stages
   for (genvar k = 0; k < ITERS; k++) begin : g_cordic
      localparam logic [31:0] ATAN = atan_turn(k);
      cord_type dx, dy;
      logic     pos;
      assign dx  = cy_ff[k] >>> k;
      assign dy  = cx_ff[k] >>> k;
      assign pos = !cz_ff[k][CORD_W-1];
      always_ff @(posedge clock) begin
         if (reset) cv_ff[k+1] <= 1'b0;
         else       cv_ff[k+1] <= cv_ff[k];
         cb_ff[k+1] <= cb_ff[k];
         cx_ff[k+1] <= pos ? cx_ff[k] - dx : cx_ff[k] + dx;
         cy_ff[k+1] <= pos ? cy_ff[k] + dy : cy_ff[k] - dy;
         cz_ff[k+1] <= pos ? cz_ff[k] - $signed(ATAN) : cz_ff[k] + $signed(ATAN);
      end
   end

   // output: round, saturate, zero before the delay
   cord_type                xr_sum, yr_sum, xr, yr;
   logic signed [OUT_W-1:0] i_in, q_in;

   function automatic logic signed [OUT_W-1:0] sat16(input cord_type v);
      logic signed [OUT_W-1:0] r;
      begin
         if (v > 32'sd32767)       r = 16'sh7FFF;
         else if (v < -32'sd32768) r = -16'sh8000;
         else                      r = v[OUT_W-1:0];
         return r;
      end
   endfunction

   assign xr_sum = cx_ff[ITERS] + 32'sd8192;
   assign yr_sum = cy_ff[ITERS] + 32'sd8192;
   assign xr     = xr_sum >>> CORD_FRAC;
   assign yr     = yr_sum >>> CORD_FRAC;
   assign i_in   = cb_ff[ITERS] ? '0 : sat16(xr);
   assign q_in   = cb_ff[ITERS] ? '0 : sat16(yr);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cv_ff[ITERS];
      rsp_i_out        <= i_in;
      rsp_q_out        <= q_in;
      rsp_before_delay <= cb_ff[ITERS];
   end

endmodule
`default_nettype wire

>>> hdl/dlcs_checker.sv
`default_nettype none
module dlcs_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               start,
   input wire                               busy,
   input wire                               rsp_valid,
   input wire [dlcs_pkg::OUT_W-1:0]         rsp_i_out,
   input wire [dlcs_pkg::OUT_W-1:0]         rsp_q_out,
   input wire                               rsp_before_delay
);
   import dlcs_pkg::*;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("missing result after start transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching start transfer");

   a_before_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_before_delay) |-> (rsp_i_out == '0 && rsp_q_out == '0))
      else $error("nonzero sample before delay");

   a_reset_idle: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind delayed_lfm_chirp_sample dlcs_checker u_dlcs_checker (.*);
`default_nettype wire
